/* rtl/arpr_pkg.sv */
// shared types and constants for the arp proxy responder
`timescale 1ns / 1ps
`default_nettype none

package arpr_pkg;

    // field widths fixed by the beat layout
    localparam int IP_W       = 32;
    localparam int MAC_W      = 48;
    localparam int WORD_W     = 64;
    localparam int BYTES_W    = 4;
    localparam int INDEX_W    = 4;

    // beat kinds carried in tuser
    localparam logic OP_TABLE = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // arp header handling
    localparam int             HDR_WORDS      = 6;
    localparam logic [3:0]     MIN_LAST_BYTES = 4'd2;
    localparam logic [3:0]     FULL_WORD      = 4'd8;
    localparam logic [15:0]    REQUEST_OPCODE = 16'h0001;
    localparam logic [7:0]     REPLY_OPCODE   = 8'h02;

    // top level sequencer
    typedef enum logic [2:0] {
        ST_RECV,
        ST_CHECK,
        ST_LOOKUP,
        ST_READ,
        ST_FILL,
        ST_SEND
    } arpr_state_t;

    // outcome of a table search
    typedef struct packed {
        logic                 done;
        logic                 hit;
        logic [INDEX_W-1:0]   entry;
        logic [MAC_W-1:0]     mac;
    } lookup_res_t;

endpackage

`default_nettype wire

/* rtl/arpr_table.sv */
// address table memory with a sequential lowest-entry search
`timescale 1ns / 1ps
`default_nettype none

module arpr_table
    import arpr_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [INDEX_W-1:0]   wr_index,
    input  wire logic [IP_W-1:0]      wr_ip,
    input  wire logic [MAC_W-1:0]     wr_mac,
    input  wire logic                 search_start,
    input  wire logic [IP_W-1:0]      search_ip,
    output lookup_res_t               result
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CMP_W = ((IDX_W > INDEX_W) ? IDX_W : INDEX_W) + 1;

    // table storage, ip in the upper bits
    logic [IP_W+MAC_W-1:0]      mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]   valid_reg;

    logic [IP_W+MAC_W-1:0]      rd_data_reg;
    logic                       rd_valid_reg;
    logic                       busy_reg;
    logic                       pend_reg;
    logic [IDX_W-1:0]           pend_idx_reg;
    logic [IDX_W:0]             issue_reg;
    logic [IP_W-1:0]            target_reg;
    logic                       done_reg;
    logic                       hit_reg;
    logic [INDEX_W-1:0]         entry_reg;
    logic [MAC_W-1:0]           mac_reg;

    logic [CMP_W-1:0]           wr_ext;
    logic                       wr_ok;
    logic [IDX_W-1:0]           wr_addr;
    logic                       issue_more;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic [IP_W-1:0]            eff_ip;
    logic                       match;

    // write side, entries past the table are ignored
    assign wr_ext  = CMP_W'(wr_index);
    assign wr_ok   = wr_en && (wr_ext < CMP_W'(TABLE_ENTRIES));
    assign wr_addr = wr_ext[IDX_W-1:0];

    // search read side
    assign issue_more = issue_reg < (IDX_W+1)'(TABLE_ENTRIES);
    assign rd_en      = busy_reg && issue_more;
    assign rd_addr    = issue_reg[IDX_W-1:0];
    assign eff_ip     = rd_valid_reg ? rd_data_reg[IP_W+MAC_W-1:MAC_W] : '0;
    assign match      = pend_reg && (eff_ip == target_reg);

    // memory array
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_addr] <= {wr_ip, wr_mac};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // valid bits, unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // search sequencer, one entry compared per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            issue_reg    <= '0;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else if (search_start)
        begin
            busy_reg  <= 1'b1;
            pend_reg  <= 1'b0;
            issue_reg <= '0;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else if (busy_reg)
        begin
            pend_reg     <= issue_more;
            pend_idx_reg <= rd_addr;
            if (issue_more)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (match)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
                hit_reg  <= 1'b1;
            end
            else if (!issue_more && pend_reg)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // search key and hit payload, an unwritten entry gives a zero mac
    always_ff @(posedge clk)
    begin
        if (search_start)
        begin
            target_reg <= search_ip;
        end
        if (busy_reg && match)
        begin
            entry_reg <= INDEX_W'(pend_idx_reg);
            mac_reg   <= rd_valid_reg ? rd_data_reg[MAC_W-1:0] : '0;
        end
    end

    assign result.done  = done_reg;
    assign result.hit   = hit_reg;
    assign result.entry = entry_reg;
    assign result.mac   = mac_reg;

endmodule

`default_nettype wire

/* rtl/arpr_frame_buf.sv */
// frame word buffer with fill count and overflow tracking
`timescale 1ns / 1ps
`default_nettype none

module arpr_frame_buf
    import arpr_pkg::*;
#(
    parameter int BUFFER_WORDS = 16
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  beat_en,
    input  wire logic                                  beat_last,
    input  wire logic [WORD_W-1:0]                     beat_data,
    input  wire logic                                  rd_en,
    input  wire logic [$clog2(BUFFER_WORDS)-1:0]       rd_addr,
    output logic      [WORD_W-1:0]                     rd_data,
    output logic      [$clog2(BUFFER_WORDS+1)-1:0]     count,
    output logic                                       overflow
);

    localparam int AW = $clog2(BUFFER_WORDS);
    localparam int CW = $clog2(BUFFER_WORDS + 1);

    logic [WORD_W-1:0]  mem [BUFFER_WORDS];
    logic [WORD_W-1:0]  rd_data_reg;
    logic [CW-1:0]      count_reg;
    logic               ovf_reg;
    logic               room;

    assign room = count_reg < CW'(BUFFER_WORDS);

    // word storage
    always_ff @(posedge clk)
    begin
        if (beat_en && room)
        begin
            mem[count_reg[AW-1:0]] <= beat_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // fill count and overflow, cleared at the end of every frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (beat_en)
        begin
            if (beat_last)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (room)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign count    = count_reg;
    assign overflow = ovf_reg;

endmodule

`default_nettype wire

/* rtl/arp_proxy_responder.sv */
// arp proxy responder top level: receive, check, table search and reply
// Frame beats are taken one per cycle while receiving; table beats likewise.
// After the last beat of a frame no beat is taken until the frame is dropped
// or answered: a check state, then a search of the address table.
// Each reply beat goes through a buffer read, an output load and a handshake.
// Reset clears the table (valid bits) and the frame state at once; the
// frame buffer contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module arp_proxy_responder
    import arpr_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int BUFFER_WORDS  = 16
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    // entry_index[3:0], entry_ip[35:4], entry_mac[83:36],
    // frame_data[147:84], valid_bytes[151:148]
    input  wire logic [151:0]   s_axis_tdata,
    // op
    input  wire logic           s_axis_tuser,
    input  wire logic           s_axis_tlast,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // resp_data[63:0], resp_bytes[67:64], matched_entry[71:68]
    output logic      [71:0]    m_axis_tdata,
    output logic                m_axis_tlast
);

    localparam int AW = $clog2(BUFFER_WORDS);
    localparam int CW = $clog2(BUFFER_WORDS + 1);

    arpr_state_t            state_reg, state_next;
    lookup_res_t            lres;

    logic                   in_beat;
    logic                   tbl_wr;
    logic                   frm_beat;
    logic [INDEX_W-1:0]     in_index;
    logic [IP_W-1:0]        in_ip;
    logic [MAC_W-1:0]       in_mac;
    logic [WORD_W-1:0]      in_data;
    logic [BYTES_W-1:0]     in_vb;
    logic [BYTES_W-1:0]     vb_norm;

    logic [WORD_W-1:0]      buf_rd_data;
    logic [CW-1:0]          buf_count;
    logic                   buf_ovf;
    logic                   buf_rd_en;
    logic                   search_start;

    logic [WORD_W-1:0]      hdr_reg [HDR_WORDS];
    logic [CW-1:0]          nwords_reg;
    logic [BYTES_W-1:0]     vb_reg;
    logic                   ovf_reg;
    logic [CW-1:0]          k_reg;
    logic [WORD_W-1:0]      out_data_reg;
    logic [BYTES_W-1:0]     out_bytes_reg;
    logic                   out_last_reg;
    logic [INDEX_W-1:0]     out_entry_reg;

    logic [IP_W-1:0]        target_ip;
    logic [47:0]            old_src;
    logic [79:0]            old_snd;
    logic [WORD_W-1:0]      rw_word [HDR_WORDS];
    logic                   short_frame;
    logic                   not_request;
    logic                   last_word;
    logic [WORD_W-1:0]      word_sel;
    logic [WORD_W-1:0]      keep_mask;
    logic [5:0]             drop_bits;

    // beat unpacking
    assign in_index = s_axis_tdata[3:0];
    assign in_ip    = s_axis_tdata[35:4];
    assign in_mac   = s_axis_tdata[83:36];
    assign in_data  = s_axis_tdata[147:84];
    assign in_vb    = s_axis_tdata[151:148];
    assign vb_norm  = (in_vb == 4'd0 || in_vb > FULL_WORD) ? FULL_WORD : in_vb;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign tbl_wr   = in_beat && (s_axis_tuser == OP_TABLE);
    assign frm_beat = in_beat && (s_axis_tuser == OP_FRAME);

    arpr_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (tbl_wr),
        .wr_index     (in_index),
        .wr_ip        (in_ip),
        .wr_mac       (in_mac),
        .search_start (search_start),
        .search_ip    (target_ip),
        .result       (lres)
    );

    arpr_frame_buf #(
        .BUFFER_WORDS (BUFFER_WORDS)
    ) u_frame_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat_en   (frm_beat),
        .beat_last (s_axis_tlast),
        .beat_data (in_data),
        .rd_en     (buf_rd_en),
        .rd_addr   (k_reg[AW-1:0]),
        .rd_data   (buf_rd_data),
        .count     (buf_count),
        .overflow  (buf_ovf)
    );

    // header fields of the buffered arp frame
    assign target_ip   = {hdr_reg[4][15:0], hdr_reg[5][63:48]};
    assign old_src     = {hdr_reg[0][15:0], hdr_reg[1][63:32]};
    assign old_snd     = {hdr_reg[2][15:0], hdr_reg[3]};
    assign not_request = hdr_reg[2][31:16] != REQUEST_OPCODE;
    assign short_frame = (nwords_reg < CW'(HDR_WORDS)) ||
                         ((nwords_reg == CW'(HDR_WORDS)) && (vb_reg < MIN_LAST_BYTES));

    // rewritten header words of the reply
    assign rw_word[0] = {old_src, lres.mac[47:32]};
    assign rw_word[1] = {lres.mac[31:0], hdr_reg[1][31:0]};
    assign rw_word[2] = {hdr_reg[2][63:32], 8'h00, REPLY_OPCODE, lres.mac[47:32]};
    assign rw_word[3] = {lres.mac[31:0], target_ip};
    assign rw_word[4] = old_snd[79:16];
    assign rw_word[5] = {old_snd[15:0], hdr_reg[5][47:0]};

    // reply word selection and tail masking
    assign last_word = k_reg == (nwords_reg - CW'(1));
    assign word_sel  = (k_reg < CW'(HDR_WORDS)) ? rw_word[k_reg[2:0]] : buf_rd_data;
    assign drop_bits = {vb_reg[2:0], 3'b000};
    assign keep_mask = (last_word && vb_reg < FULL_WORD) ? ~({WORD_W{1'b1}} >> drop_bits)
                                                          : {WORD_W{1'b1}};

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and handshake control
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        search_start  = 1'b0;
        buf_rd_en     = 1'b0;
        unique case (state_reg)
            ST_RECV:
            begin
                s_axis_tready = 1'b1;
                if (frm_beat && s_axis_tlast)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (ovf_reg || short_frame || not_request)
                begin
                    state_next = ST_RECV;
                end
                else
                begin
                    search_start = 1'b1;
                    state_next   = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (lres.done)
                begin
                    state_next = lres.hit ? ST_READ : ST_RECV;
                end
            end
            ST_READ:
            begin
                buf_rd_en  = 1'b1;
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    state_next = out_last_reg ? ST_RECV : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    // frame summary captured at the last beat, reply word counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nwords_reg <= '0;
            vb_reg     <= FULL_WORD;
            ovf_reg    <= 1'b0;
            k_reg      <= '0;
        end
        else
        begin
            if (frm_beat && s_axis_tlast)
            begin
                nwords_reg <= buf_count + 1'b1;
                vb_reg     <= vb_norm;
                ovf_reg    <= buf_ovf || (buf_count >= CW'(BUFFER_WORDS));
            end
            if (state_reg == ST_LOOKUP)
            begin
                k_reg <= '0;
            end
            else if (state_reg == ST_SEND && m_axis_tready)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // header words kept beside the buffer for the rewrite
    always_ff @(posedge clk)
    begin
        if (frm_beat && buf_count < CW'(HDR_WORDS))
        begin
            hdr_reg[buf_count[2:0]] <= in_data;
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FILL)
        begin
            out_data_reg  <= word_sel & keep_mask;
            out_bytes_reg <= last_word ? vb_reg : FULL_WORD;
            out_last_reg  <= last_word;
            out_entry_reg <= lres.entry;
        end
    end

    assign m_axis_tdata = {out_entry_reg, out_bytes_reg, out_data_reg};
    assign m_axis_tlast = out_last_reg;

endmodule

`default_nettype wire
